// ===== hw/rtl/crb_pkg.sv =====
// Shared types, constants and helpers for the cursor bitmap expander.
package crb_pkg;

  localparam int LANES     = 8;
  localparam int CNT_W     = 4;
  localparam int PIX_W     = 32;
  localparam int BYTE_W    = 8;
  localparam int COLOR_W   = 48;
  localparam int DIM_W     = 9;
  localparam int ROW_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] MAX_HEIGHT = 9'd256;
  localparam logic [DIM_W-1:0] DIM_RESET  = 9'd16;
  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hff00_0000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARGB_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             last;
  } crb_res_t;

  typedef struct packed {
    crb_res_t [LANES-1:0] res;
    logic [CNT_W-1:0]     cnt;
  } crb_burst_t;

  // opaque ARGB from the high bytes of the 16-bit R, G, B channels
  function automatic logic [PIX_W-1:0] opaque_color(input logic [COLOR_W-1:0] c);
    return ALPHA_OPAQUE | {8'h00, c[47:40], c[31:24], c[15:8]};
  endfunction

endpackage

// ===== hw/rtl/crb_if.sv =====
// Request channel interfaces: bitmap input and ARGB pixel output.
interface crb_in_if import crb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_byte;
  logic [BYTE_W-1:0] mask_byte;
  logic [PIX_W-1:0]  argb_pixel;

  modport source (output valid, source_byte, mask_byte, argb_pixel, input ready);
  modport sink   (input valid, source_byte, mask_byte, argb_pixel, output ready);
endinterface

interface crb_out_if import crb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             row_end;
  logic             last;

  modport source (output valid, pixel, row_end, last, input ready);
  modport sink   (input valid, pixel, row_end, last, output ready);
endinterface

// ===== hw/rtl/cursor_bitmap_to_argb.sv =====
// Cursor bitmap expander top level: config registers, position counters, lanes.
//
// Usage: each request on in_chan carries one byte of the source plane and one
// of the mask plane (bitmap mode) or one ready ARGB pixel (argb_mode = 1).
// A bitmap byte expands into up to eight pixels on out_chan, left to right;
// padding bits and padding bytes at the end of a scanline give no pixel.
// row_end marks the last pixel of a row, last the last pixel of the image.
// Registers are written over cfg_we/cfg_index/cfg_wdata while the block is
// idle; a write of argb_mode, image_width or image_height restarts the image.
// With the block empty, an accepted request passes the pending register and
// then the drain buffer before its first pixel is on out_chan.
// Throughput: eight lanes expand a byte at once, and the output drains one
// pixel per cycle while out_chan is ready. One request waits in a pending
// register while the previous one drains, so in_chan keeps flowing while
// out_chan is busy.
// A stall on out_chan holds the current pixel and backs up into in_chan once
// the pending register is full.
// Reset: colors 0, MSB-first bit order, bitmap mode, 16x16, counters at 0.
module cursor_bitmap_to_argb import crb_pkg::*; #(
  parameter int MAX_WIDTH         = 256,
  parameter int SCANLINE_PAD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata,
  crb_in_if.sink               in_chan,
  crb_out_if.source            out_chan
);

  localparam int CW_RAW = $clog2(MAX_WIDTH + 2 * SCANLINE_PAD_BITS + 16);
  localparam int CW     = (CW_RAW > DIM_W + 1) ? CW_RAW : DIM_W + 1;
  localparam logic [CW-1:0] PAD = CW'(SCANLINE_PAD_BITS);
  localparam logic [CW-1:0] WMAX = CW'(MAX_WIDTH);

  // configuration registers
  logic [COLOR_W-1:0] fore_r, back_r;
  logic               lsb_first_r, argb_mode_r;
  logic [DIM_W-1:0]   width_r, height_r;

  // position state
  logic [CW-1:0]    pixel_column_r, pixel_column_nxt;
  logic [CW-4:0]    byte_in_row_r, byte_in_row_nxt;
  logic [CW-1:0]    pw_end_r, pw_end_nxt;
  logic [ROW_W-1:0] row_index_r, row_index_nxt;

  logic [CW-1:0]    w_ext, w_cl;
  logic [DIM_W-1:0] h_cl;
  logic             last_row;
  logic [ROW_W-1:0] row_next;
  logic [CW-1:0]    base, nb;
  logic             byte_row_end;
  logic             argb_row_end;
  logic             accept;
  logic             geom_write;
  logic [PIX_W-1:0] fg, bg;

  logic [LANES-1:0] lane_vld;
  crb_res_t         lane_res [LANES];
  crb_burst_t       burst;
  logic             burst_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r      <= '0;
      back_r      <= '0;
      lsb_first_r <= 1'b0;
      argb_mode_r <= 1'b0;
      width_r     <= DIM_RESET;
      height_r    <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORE_COLOR:   fore_r      <= cfg_wdata;
        CFG_BACK_COLOR:   back_r      <= cfg_wdata;
        CFG_LSB_FIRST:    lsb_first_r <= cfg_wdata[0];
        CFG_ARGB_MODE:    argb_mode_r <= cfg_wdata[0];
        CFG_IMAGE_WIDTH:  width_r     <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r    <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom_write = cfg_we && (cfg_index == CFG_ARGB_MODE ||
                                 cfg_index == CFG_IMAGE_WIDTH ||
                                 cfg_index == CFG_IMAGE_HEIGHT);

  // clamped geometry
  assign w_ext = CW'(width_r);
  always_comb begin
    if (width_r == '0) begin
      w_cl = CW'(1);
    end else if (w_ext > WMAX) begin
      w_cl = WMAX;
    end else begin
      w_cl = w_ext;
    end
    if (height_r == '0) begin
      h_cl = DIM_W'(1);
    end else if (height_r > MAX_HEIGHT) begin
      h_cl = MAX_HEIGHT;
    end else begin
      h_cl = height_r;
    end
  end

  assign last_row = ({1'b0, row_index_r} + DIM_W'(1)) >= h_cl;
  assign row_next = last_row ? '0 : row_index_r + ROW_W'(1);

  assign fg = opaque_color(fore_r);
  assign bg = opaque_color(back_r);

  // pw_end_r is the end of the pad word holding the current byte; the row
  // ends on the first byte that reaches the padded row length
  assign base = {byte_in_row_r, 3'b000};
  assign nb   = base + CW'(BYTE_W);
  assign byte_row_end = ((w_cl <= pw_end_r) && (nb >= pw_end_r)) ||
                        (w_cl <= pw_end_r - PAD);
  assign argb_row_end = (pixel_column_r + CW'(1)) >= w_cl;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = burst_ready;

  always_comb begin
    pixel_column_nxt = pixel_column_r;
    byte_in_row_nxt  = byte_in_row_r;
    pw_end_nxt       = pw_end_r;
    row_index_nxt    = row_index_r;
    if (geom_write) begin
      pixel_column_nxt = '0;
      byte_in_row_nxt  = '0;
      pw_end_nxt       = PAD;
      row_index_nxt    = '0;
    end else if (accept) begin
      if (argb_mode_r) begin
        if (argb_row_end) begin
          pixel_column_nxt = '0;
          row_index_nxt    = row_next;
        end else begin
          pixel_column_nxt = pixel_column_r + CW'(1);
        end
      end else if (byte_row_end) begin
        byte_in_row_nxt = '0;
        pw_end_nxt      = PAD;
        row_index_nxt   = row_next;
      end else begin
        byte_in_row_nxt = byte_in_row_r + (CW-3)'(1);
        if (nb >= pw_end_r) begin
          pw_end_nxt = pw_end_r + PAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_column_r <= '0;
      byte_in_row_r  <= '0;
      pw_end_r       <= PAD;
      row_index_r    <= '0;
    end else begin
      pixel_column_r <= pixel_column_nxt;
      byte_in_row_r  <= byte_in_row_nxt;
      pw_end_r       <= pw_end_nxt;
      row_index_r    <= row_index_nxt;
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic s_bit, m_bit;
    assign s_bit = lsb_first_r ? in_chan.source_byte[b] : in_chan.source_byte[LANES-1-b];
    assign m_bit = lsb_first_r ? in_chan.mask_byte[b]   : in_chan.mask_byte[LANES-1-b];

    crb_lane #(.CW(CW)) u_lane (
      .src_bit  (s_bit),
      .msk_bit  (m_bit),
      .col      (base + CW'(b)),
      .width    (w_cl),
      .fg       (fg),
      .bg       (bg),
      .last_row (last_row),
      .valid    (lane_vld[b]),
      .res      (lane_res[b])
    );
  end

  // merge: valid lanes form a prefix, so the count is all the packing needed
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      burst.res[i] = lane_res[i];
    end
    burst.cnt = CNT_W'($countones(lane_vld));
    if (argb_mode_r) begin
      burst.res[0].pixel   = in_chan.argb_pixel;
      burst.res[0].row_end = argb_row_end;
      burst.res[0].last    = argb_row_end & last_row;
      burst.cnt            = CNT_W'(1);
    end
  end

  crb_drain u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst_valid (in_chan.valid),
    .burst_ready (burst_ready),
    .burst       (burst),
    .out_chan    (out_chan)
  );

  // image end is always a row end
  a_last_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (!out_chan.last || out_chan.row_end))
    else $error("last without row_end");

  a_geom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    geom_write |=> (pixel_column_r == '0 && byte_in_row_r == '0 &&
                    row_index_r == '0 && pw_end_r == PAD))
    else $error("position not cleared after geometry write");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_index_r} < h_cl)
    else $error("row index past image height");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pixel_column_r < w_cl)
    else $error("pixel column past image width");

endmodule

// ===== hw/rtl/crb_lane.sv =====
// One pixel lane: turns a source/mask bit pair at a column into an ARGB result.
module crb_lane import crb_pkg::*; #(
  parameter int CW = 10
) (
  input  logic             src_bit,
  input  logic             msk_bit,
  input  logic [CW-1:0]    col,
  input  logic [CW-1:0]    width,
  input  logic [PIX_W-1:0] fg,
  input  logic [PIX_W-1:0] bg,
  input  logic             last_row,
  output logic             valid,
  output crb_res_t         res
);

  logic row_end;

  assign valid   = col < width;
  assign row_end = (col + CW'(1)) == width;

  always_comb begin
    if (!msk_bit) begin
      res.pixel = '0;
    end else if (src_bit) begin
      res.pixel = fg;
    end else begin
      res.pixel = bg;
    end
    res.row_end = row_end;
    res.last    = row_end & last_row;
  end

endmodule

// ===== hw/rtl/crb_drain.sv =====
// Pending burst register plus a draining shift buffer, one pixel per cycle out while out_chan is ready.
module crb_drain import crb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       burst_valid,
  output logic       burst_ready,
  input  crb_burst_t burst,
  crb_out_if.source  out_chan
);

  logic             pend_vld_r, pend_vld_nxt;
  crb_burst_t       pend_r, pend_nxt;
  crb_burst_t       drn_r, drn_nxt;
  logic [CNT_W-1:0] drn_cnt_r, drn_cnt_nxt;
  logic             fire;
  logic             load;

  assign fire = out_chan.valid & out_chan.ready;
  // drain buffer is empty or frees up this cycle
  assign load = (drn_cnt_r == '0) || ((drn_cnt_r == CNT_W'(1)) && out_chan.ready);
  assign burst_ready = !pend_vld_r || load;

  assign out_chan.valid   = drn_cnt_r != '0;
  assign out_chan.pixel   = drn_r.res[0].pixel;
  assign out_chan.row_end = drn_r.res[0].row_end;
  assign out_chan.last    = drn_r.res[0].last;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    drn_nxt      = drn_r;
    drn_cnt_nxt  = drn_cnt_r;

    if (load) begin
      if (pend_vld_r) begin
        drn_nxt     = pend_r;
        drn_cnt_nxt = pend_r.cnt;
      end else begin
        drn_cnt_nxt = '0;
      end
      pend_vld_nxt = 1'b0;
    end else if (fire) begin
      for (int i = 0; i < LANES - 1; i++) begin
        drn_nxt.res[i] = drn_r.res[i+1];
      end
      drn_cnt_nxt = drn_cnt_r - CNT_W'(1);
    end

    if (burst_valid && burst_ready) begin
      pend_nxt     = burst;
      pend_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      drn_cnt_r  <= '0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      drn_cnt_r  <= drn_cnt_nxt;
    end
    pend_r <= pend_nxt;
    drn_r  <= drn_nxt;
  end

endmodule
